/* rtl/flocking_steering_rules_macros.svh */
// Assertion macros used by the flocking steering checker
`ifndef FLOCKING_STEERING_RULES_MACROS_SVH
`define FLOCKING_STEERING_RULES_MACROS_SVH

// Check a consequence in the same cycle as its trigger
`define FSR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger
`define FSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fsr_pkg.sv */
// Shared types and constants of the flocking steering block
package fsr_pkg;

    localparam int WORD_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_IDX_W  = 6;
    localparam int STATUS_W   = 2;
    localparam int BOID_W     = 4 * WORD_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_STR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_RNG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALI_STR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COH_STR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_RNG = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD   = 3'd6;

    // Request commands
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FEW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVF = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] sep_str;
        logic [WORD_W-1:0] sep_rng;
        logic [WORD_W-1:0] ali_str;
        logic [WORD_W-1:0] coh_str;
        logic [WORD_W-1:0] int_rng;
        logic              wrap;
        logic [WORD_W-2:0] field;
    } t_cfg;

endpackage

/* rtl/fsr_if.sv */
// Request and result channel interfaces of the flocking steering block
interface fsr_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;

    modport source (output valid, command, pos_x, pos_y, vel_x, vel_y, input ready);
    modport sink   (input valid, command, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

interface fsr_out_if;
    logic               valid;
    logic               ready;
    logic [5:0]         boid_index;
    logic signed [31:0] delta_vx;
    logic signed [31:0] delta_vy;
    logic [1:0]         status;
    logic               last;

    modport source (output valid, boid_index, delta_vx, delta_vy, status, last, input ready);
    modport sink   (input valid, boid_index, delta_vx, delta_vy, status, last, output ready);
endinterface

/* rtl/flocking_steering_rules.sv */
// Top level of the flocking steering block
//
// Boids are loaded one per request (position and velocity, signed Q16.16)
// into a boid RAM; a compute request then produces one velocity change per
// stored boid, in load order, with last set on the final one. Each result
// takes one RAM read for the boid itself, a walk over its neighbours through
// the single RAM read port, a six-stage pair pipeline drain, and four
// parallel bit-serial dividers for the alignment and cohesion means. A
// compute with fewer than two boids returns one status result. Loads stall
// while a compute is queued or running; a compute request is taken while the
// job queue has room. Configuration is to be written through the plain
// write port while idle; the block itself does not enforce this.
module flocking_steering_rules #(
    parameter int MAX_BOIDS = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fsr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fsr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    fsr_in_if.sink                         i_in,
    fsr_out_if.source                      o_out
);
    localparam int CNT_W = $clog2(MAX_BOIDS + 1);
    localparam int IDX_W = $clog2(MAX_BOIDS);
    localparam int JOB_W = CNT_W + fsr_pkg::STATUS_W;

    fsr_pkg::t_cfg              r_cfg;
    logic                       q_push;
    logic                       q_pop;
    logic                       q_full;
    logic                       q_empty;
    logic [JOB_W-1:0]           q_wdata;
    logic [JOB_W-1:0]           q_rdata;
    logic                       back_busy;
    logic                       ram_we;
    logic [IDX_W-1:0]           ram_waddr;
    logic [IDX_W-1:0]           ram_raddr;
    logic [fsr_pkg::BOID_W-1:0] ram_wdata;
    logic [fsr_pkg::BOID_W-1:0] ram_rdata;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fsr_pkg::CFG_SEP_STR: r_cfg.sep_str <= i_cfg_data;
                fsr_pkg::CFG_SEP_RNG: r_cfg.sep_rng <= i_cfg_data;
                fsr_pkg::CFG_ALI_STR: r_cfg.ali_str <= i_cfg_data;
                fsr_pkg::CFG_COH_STR: r_cfg.coh_str <= i_cfg_data;
                fsr_pkg::CFG_INT_RNG: r_cfg.int_rng <= i_cfg_data;
                fsr_pkg::CFG_WRAP:    r_cfg.wrap    <= i_cfg_data[0];
                fsr_pkg::CFG_FIELD:   r_cfg.field   <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    fsr_ram #(
        .WIDTH (fsr_pkg::BOID_W),
        .DEPTH (MAX_BOIDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fsr_front #(
        .MAX_BOIDS (MAX_BOIDS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_back_busy (back_busy),
        .i_q_full    (q_full),
        .i_q_empty   (q_empty),
        .o_push      (q_push),
        .o_job       (q_wdata),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata)
    );

    fsr_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    fsr_back #(
        .MAX_BOIDS (MAX_BOIDS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (q_empty),
        .i_job       (q_rdata),
        .o_pop       (q_pop),
        .o_busy      (back_busy),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_out       (o_out)
    );
endmodule

/* rtl/fsr_ram.sv */
// Generic single-write, single-read RAM with registered read data
module fsr_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/fsr_fifo.sv */
// Short job queue between the front and the back of the flocking block
module fsr_fifo #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 2,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
    endfunction

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // Store a pushed job
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= bump(r_wp);
            end
            if (i_pop) begin
                r_rp <= bump(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= CW'(r_cnt + 1'b1);
            end else if (i_pop && !i_push) begin
                r_cnt <= CW'(r_cnt - 1'b1);
            end
        end
    end
endmodule

/* rtl/fsr_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned operands
module fsr_div #(
    parameter int DW  = 64,
    parameter int VW  = 7,
    localparam int SW = $clog2(DW + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_num,
    input  logic [VW-1:0] i_den,
    output logic          o_busy,
    output logic [DW-1:0] o_quot
);
    logic [DW-1:0] r_num;
    logic [VW-1:0] r_den;
    logic [VW-1:0] r_rem;
    logic [SW-1:0] r_steps;
    logic          r_busy;
    logic [VW:0]   trial;
    logic          fits;
    logic [VW:0]   diff;

    assign o_busy = r_busy;
    assign o_quot = r_num;

    // Shift one dividend bit into the remainder and try the subtract
    always_comb begin
        trial = {r_rem, r_num[DW-1]};
        fits  = (trial >= {1'b0, r_den});
        diff  = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_steps <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_steps <= SW'(DW);
        end else if (r_busy) begin
            r_steps <= SW'(r_steps - 1'b1);
            if (r_steps == SW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Quotient bits replace dividend bits from the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DW-2:0], fits};
            r_rem <= fits ? diff[VW-1:0] : trial[VW-1:0];
        end
    end
endmodule

/* rtl/fsr_front.sv */
// Front end: accepts requests, stores boids and queues compute jobs
module fsr_front #(
    parameter int MAX_BOIDS = 64,
    localparam int CNT_W    = $clog2(MAX_BOIDS + 1),
    localparam int IDX_W    = $clog2(MAX_BOIDS),
    localparam int JOB_W    = CNT_W + fsr_pkg::STATUS_W
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    fsr_in_if.sink                    i_in,
    input  logic                      i_back_busy,
    input  logic                      i_q_full,
    input  logic                      i_q_empty,
    output logic                      o_push,
    output logic [JOB_W-1:0]          o_job,
    output logic                      o_ram_we,
    output logic [IDX_W-1:0]          o_ram_waddr,
    output logic [fsr_pkg::BOID_W-1:0] o_ram_wdata
);
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovf;
    logic             is_cmp;
    logic             take;
    logic             room;

    // Loads wait until the previous flock is finished; computes need queue room
    assign is_cmp     = (i_in.command == fsr_pkg::CMD_COMPUTE);
    assign i_in.ready = is_cmp ? !i_q_full : (i_q_empty && !i_back_busy);
    assign take       = i_in.valid && i_in.ready;
    assign room       = (r_cnt < CNT_W'(MAX_BOIDS));

    assign o_ram_we    = take && !is_cmp && room;
    assign o_ram_waddr = r_cnt[IDX_W-1:0];
    assign o_ram_wdata = {i_in.pos_x, i_in.pos_y, i_in.vel_x, i_in.vel_y};

    assign o_push = take && is_cmp;
    assign o_job  = {(r_ovf ? fsr_pkg::ST_OVF : fsr_pkg::ST_OK), r_cnt};

    // Count loaded boids, flag dropped loads, restart after a compute
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (take) begin
            if (is_cmp) begin
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end else if (room) begin
                r_cnt <= CNT_W'(r_cnt + 1'b1);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end
endmodule

/* rtl/fsr_back.sv */
// Back end: walks all boid pairs of a job and emits one steering result per boid, or one for a small flock
module fsr_back #(
    parameter int MAX_BOIDS = 64,
    parameter int FRAC_BITS = 16,
    localparam int CNT_W    = $clog2(MAX_BOIDS + 1),
    localparam int IDX_W    = $clog2(MAX_BOIDS),
    localparam int JOB_W    = CNT_W + fsr_pkg::STATUS_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  fsr_pkg::t_cfg              i_cfg,
    input  logic                       i_q_empty,
    input  logic [JOB_W-1:0]           i_job,
    output logic                       o_pop,
    output logic                       o_busy,
    output logic [IDX_W-1:0]           o_ram_raddr,
    input  logic [fsr_pkg::BOID_W-1:0] i_ram_rdata,
    fsr_out_if.source                  o_out
);
    localparam int SW = 4;
    localparam logic [SW-1:0] S_IDLE  = 4'd0;
    localparam logic [SW-1:0] S_FEW   = 4'd1;
    localparam logic [SW-1:0] S_RDI   = 4'd2;
    localparam logic [SW-1:0] S_LATI  = 4'd3;
    localparam logic [SW-1:0] S_WALK  = 4'd4;
    localparam logic [SW-1:0] S_DRAIN = 4'd5;
    localparam logic [SW-1:0] S_DIV   = 4'd6;
    localparam logic [SW-1:0] S_MUL   = 4'd7;
    localparam logic [SW-1:0] S_ADD1  = 4'd8;
    localparam logic [SW-1:0] S_ADD2  = 4'd9;
    localparam logic [SW-1:0] S_OUT   = 4'd10;

    // Control
    logic [SW-1:0]             r_state;
    logic [SW-1:0]             n_state;
    logic [CNT_W-1:0]          r_n;
    logic [fsr_pkg::STATUS_W-1:0] r_status;
    logic [CNT_W-1:0]          r_i;
    logic [CNT_W-1:0]          r_j;
    logic [5:0]                r_v;
    logic                      issue;
    logic                      div_start;
    logic                      out_free;
    logic                      is_last;
    logic [CNT_W-1:0]          job_n;
    logic [CNT_W+5:0]          idx_ext;

    // Squared ranges and the current boid
    logic [63:0]        r_rs2;
    logic [63:0]        r_ri2;
    logic signed [31:0] r_pix, r_piy, r_vix, r_viy;

    // Pair pipeline
    logic signed [32:0] r_dx, r_dy, r_dvx, r_dvy;
    logic [31:0]        r_mdx, r_mdy, r_mdvx, r_mdvy;
    logic               r_ndx, r_ndy, r_ndvx, r_ndvy;
    logic signed [34:0] r_ox2, r_oy2;
    logic [63:0]        r_sqx, r_sqy, r_psx, r_psy, r_pax, r_pay;
    logic               r_ndx3, r_ndy3, r_ndvx3, r_ndvy3;
    logic [31:0]        r_mox, r_moy;
    logic               r_obig3;
    logic signed [34:0] r_ox3, r_oy3;
    logic [63:0]        r_sqox, r_sqoy;
    logic               r_sepin4, r_intin4, r_obig4;
    logic signed [63:0] r_tsx4, r_tsy4, r_tax4, r_tay4;
    logic signed [34:0] r_ox4, r_oy4;
    logic               r_sepin5, r_intin5, r_cohin5;
    logic signed [63:0] r_tsx5, r_tsy5, r_tax5, r_tay5;
    logic signed [34:0] r_ox5, r_oy5;
    logic [64:0]        sumd;
    logic [64:0]        sumo;
    logic [34:0]        mox;
    logic [34:0]        moy;

    // Accumulators
    logic signed [63:0] r_sx, r_sy, r_ax, r_ay, r_cx, r_cy;
    logic [CNT_W-1:0]   r_acnt, r_ccnt;

    // Divide and combine
    logic [3:0]         div_busy;
    logic [63:0]        div_num  [4];
    logic [CNT_W-1:0]   div_den  [4];
    logic [63:0]        div_quot [4];
    logic signed [63:0] r_qax, r_qay;
    logic [63:0]        r_pcx, r_pcy;
    logic               r_ncx, r_ncy, r_cz;
    logic signed [63:0] r_ccx, r_ccy;
    logic signed [65:0] r_t1x, r_t1y, r_tx, r_ty;
    logic [31:0]        mcx, mcy;
    logic [63:0]        shx, shy;

    // Result register
    logic                         r_ovalid;
    logic [5:0]                   r_oidx;
    logic signed [31:0]           r_odx, r_ody;
    logic [fsr_pkg::STATUS_W-1:0] r_ost;
    logic                         r_olast;

    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic signed [32:0] t;
        t = v[32] ? -v : v;
        return t[31:0];
    endfunction

    function automatic logic [34:0] mag35(input logic signed [34:0] v);
        return v[34] ? 35'(-v) : 35'(v);
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // Toroidal offset of one axis
    function automatic logic signed [34:0] wrap_off(input logic signed [32:0] d,
                                                    input logic wrap,
                                                    input logic [30:0] side);
        logic signed [34:0] d35;
        logic signed [34:0] l35;
        logic signed [34:0] d2;
        d35 = 35'(d);
        l35 = $signed({4'b0000, side});
        d2  = d35 <<< 1;
        if (wrap && (d2 > l35)) begin
            return d35 - l35;
        end else if (wrap && (d2 < -l35)) begin
            return d35 + l35;
        end
        return d35;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] t);
        if (!t[65] && (|t[64:31])) begin
            return 32'sh7FFF_FFFF;
        end else if (t[65] && !(&t[64:31])) begin
            return 32'sh8000_0000;
        end
        return t[31:0];
    endfunction

    assign job_n    = i_job[CNT_W-1:0];
    assign out_free = !r_ovalid || o_out.ready;
    assign is_last  = (r_i == CNT_W'(r_n - 1'b1));
    assign idx_ext  = {6'b000000, r_i};
    assign o_busy   = (r_state != S_IDLE);
    assign o_ram_raddr = (r_state == S_WALK) ? r_j[IDX_W-1:0] : r_i[IDX_W-1:0];

    assign o_out.valid      = r_ovalid;
    assign o_out.boid_index = r_oidx;
    assign o_out.delta_vx   = r_odx;
    assign o_out.delta_vy   = r_ody;
    assign o_out.status     = r_ost;
    assign o_out.last       = r_olast;

    // Sequence a job: read boid, walk neighbours, drain, divide, combine, emit; a small flock emits one status result
    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        issue     = 1'b0;
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_state = (job_n < CNT_W'(2)) ? S_FEW : S_RDI;
                end
            end
            S_FEW: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_RDI:  n_state = S_LATI;
            S_LATI: n_state = S_WALK;
            S_WALK: begin
                issue = 1'b1;
                if (r_j == CNT_W'(r_n - 1'b1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_v == '0) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_busy == '0) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = S_ADD1;
            S_ADD1: n_state = S_ADD2;
            S_ADD2: n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = is_last ? S_IDLE : S_RDI;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold control state and the result handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_v      <= '0;
            r_ovalid <= 1'b0;
            r_n      <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_status <= fsr_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_v     <= {r_v[4:0], issue && (r_j != r_i)};
            if (r_state == S_IDLE && !i_q_empty) begin
                r_n      <= job_n;
                r_status <= i_job[JOB_W-1:CNT_W];
                r_i      <= '0;
            end
            if (r_state == S_LATI) begin
                r_j <= '0;
            end else if (r_state == S_WALK) begin
                r_j <= CNT_W'(r_j + 1'b1);
            end
            if (r_state == S_OUT && out_free && !is_last) begin
                r_i <= CNT_W'(r_i + 1'b1);
            end
            if ((r_state == S_FEW || r_state == S_OUT) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Load a result when the output register frees up
    always_ff @(posedge i_clk) begin
        if (r_state == S_FEW && out_free) begin
            r_oidx  <= '0;
            r_odx   <= '0;
            r_ody   <= '0;
            r_ost   <= fsr_pkg::ST_FEW;
            r_olast <= 1'b1;
        end else if (r_state == S_OUT && out_free) begin
            r_oidx  <= idx_ext[5:0];
            r_odx   <= sat32(r_tx);
            r_ody   <= sat32(r_ty);
            r_ost   <= r_status;
            r_olast <= is_last;
        end
    end

    // Square both ranges once per job
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_rs2 <= i_cfg.sep_rng * i_cfg.sep_rng;
            r_ri2 <= i_cfg.int_rng * i_cfg.int_rng;
        end
    end

    // Latch the current boid
    always_ff @(posedge i_clk) begin
        if (r_state == S_LATI) begin
            r_pix <= i_ram_rdata[127:96];
            r_piy <= i_ram_rdata[95:64];
            r_vix <= i_ram_rdata[63:32];
            r_viy <= i_ram_rdata[31:0];
        end
    end

    // Distance tests on the registered products
    always_comb begin
        sumd = {1'b0, r_sqx} + {1'b0, r_sqy};
        sumo = {1'b0, r_sqox} + {1'b0, r_sqoy};
        mox  = mag35(r_ox2);
        moy  = mag35(r_oy2);
    end

    // Pair pipeline: differences, magnitudes and wrap, products, tests
    always_ff @(posedge i_clk) begin
        r_dx  <= 33'($signed(i_ram_rdata[127:96])) - 33'(r_pix);
        r_dy  <= 33'($signed(i_ram_rdata[95:64])) - 33'(r_piy);
        r_dvx <= 33'($signed(i_ram_rdata[63:32])) - 33'(r_vix);
        r_dvy <= 33'($signed(i_ram_rdata[31:0])) - 33'(r_viy);

        r_mdx  <= mag33(r_dx);
        r_mdy  <= mag33(r_dy);
        r_mdvx <= mag33(r_dvx);
        r_mdvy <= mag33(r_dvy);
        r_ndx  <= r_dx[32];
        r_ndy  <= r_dy[32];
        r_ndvx <= r_dvx[32];
        r_ndvy <= r_dvy[32];
        r_ox2  <= wrap_off(r_dx, i_cfg.wrap, i_cfg.field);
        r_oy2  <= wrap_off(r_dy, i_cfg.wrap, i_cfg.field);

        r_sqx   <= r_mdx * r_mdx;
        r_sqy   <= r_mdy * r_mdy;
        r_psx   <= r_mdx * i_cfg.sep_str;
        r_psy   <= r_mdy * i_cfg.sep_str;
        r_pax   <= r_mdvx * i_cfg.ali_str;
        r_pay   <= r_mdvy * i_cfg.ali_str;
        r_ndx3  <= r_ndx;
        r_ndy3  <= r_ndy;
        r_ndvx3 <= r_ndvx;
        r_ndvy3 <= r_ndvy;
        r_mox   <= mox[31:0];
        r_moy   <= moy[31:0];
        r_obig3 <= (|mox[34:32]) || (|moy[34:32]);
        r_ox3   <= r_ox2;
        r_oy3   <= r_oy2;

        r_sqox   <= r_mox * r_mox;
        r_sqoy   <= r_moy * r_moy;
        r_sepin4 <= !sumd[64] && (sumd[63:0] < r_rs2);
        r_intin4 <= !sumd[64] && (sumd[63:0] < r_ri2);
        r_tsx4   <= r_ndx3 ? $signed(r_psx >> FRAC_BITS) : -$signed(r_psx >> FRAC_BITS);
        r_tsy4   <= r_ndy3 ? $signed(r_psy >> FRAC_BITS) : -$signed(r_psy >> FRAC_BITS);
        r_tax4   <= r_ndvx3 ? -$signed(r_pax >> FRAC_BITS) : $signed(r_pax >> FRAC_BITS);
        r_tay4   <= r_ndvy3 ? -$signed(r_pay >> FRAC_BITS) : $signed(r_pay >> FRAC_BITS);
        r_obig4  <= r_obig3;
        r_ox4    <= r_ox3;
        r_oy4    <= r_oy3;

        r_cohin5 <= !r_obig4 && !sumo[64] && (sumo[63:0] < r_ri2);
        r_sepin5 <= r_sepin4;
        r_intin5 <= r_intin4;
        r_tsx5   <= r_tsx4;
        r_tsy5   <= r_tsy4;
        r_tax5   <= r_tax4;
        r_tay5   <= r_tay4;
        r_ox5    <= r_ox4;
        r_oy5    <= r_oy4;
    end

    // Clear per boid, then add each neighbour's contributions
    always_ff @(posedge i_clk) begin
        if (r_state == S_LATI) begin
            r_sx   <= '0;
            r_sy   <= '0;
            r_ax   <= '0;
            r_ay   <= '0;
            r_cx   <= '0;
            r_cy   <= '0;
            r_acnt <= '0;
            r_ccnt <= '0;
        end else if (r_v[5]) begin
            if (r_sepin5) begin
                r_sx <= r_sx + r_tsx5;
                r_sy <= r_sy + r_tsy5;
            end
            if (r_intin5) begin
                r_ax   <= r_ax + r_tax5;
                r_ay   <= r_ay + r_tay5;
                r_acnt <= CNT_W'(r_acnt + 1'b1);
            end
            if (r_cohin5) begin
                r_cx   <= r_cx + 64'(r_ox5);
                r_cy   <= r_cy + 64'(r_oy5);
                r_ccnt <= CNT_W'(r_ccnt + 1'b1);
            end
        end
    end

    // Divide alignment and cohesion sums by their neighbour counts
    assign div_num[0] = mag64(r_ax);
    assign div_num[1] = mag64(r_ay);
    assign div_num[2] = mag64(r_cx);
    assign div_num[3] = mag64(r_cy);
    assign div_den[0] = r_acnt;
    assign div_den[1] = r_acnt;
    assign div_den[2] = r_ccnt;
    assign div_den[3] = r_ccnt;

    for (genvar k = 0; k < 4; k++) begin : g_div
        fsr_div #(
            .DW (64),
            .VW (CNT_W)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (div_start),
            .i_num   (div_num[k]),
            .i_den   (div_den[k]),
            .o_busy  (div_busy[k]),
            .o_quot  (div_quot[k])
        );
    end

    // Clamp the cohesion means and scale them by the gain
    always_comb begin
        mcx = (|div_quot[2][63:32]) ? 32'hFFFF_FFFF : div_quot[2][31:0];
        mcy = (|div_quot[3][63:32]) ? 32'hFFFF_FFFF : div_quot[3][31:0];
        shx = r_pcx >> FRAC_BITS;
        shy = r_pcy >> FRAC_BITS;
    end

    // Combine the three rules per axis
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_qax <= (r_acnt == '0) ? '0 :
                     (r_ax[63] ? -$signed(div_quot[0]) : $signed(div_quot[0]));
            r_qay <= (r_acnt == '0) ? '0 :
                     (r_ay[63] ? -$signed(div_quot[1]) : $signed(div_quot[1]));
            r_pcx <= mcx * i_cfg.coh_str;
            r_pcy <= mcy * i_cfg.coh_str;
            r_ncx <= r_cx[63];
            r_ncy <= r_cy[63];
            r_cz  <= (r_ccnt == '0);
        end
        if (r_state == S_ADD1) begin
            r_t1x <= 66'(r_sx) + 66'(r_qax);
            r_t1y <= 66'(r_sy) + 66'(r_qay);
            r_ccx <= r_cz ? '0 : (r_ncx ? -$signed(shx) : $signed(shx));
            r_ccy <= r_cz ? '0 : (r_ncy ? -$signed(shy) : $signed(shy));
        end
        if (r_state == S_ADD2) begin
            r_tx <= r_t1x + 66'(r_ccx);
            r_ty <= r_t1y + 66'(r_ccy);
        end
    end
endmodule

/* rtl/fsr_checker.sv */
// Port-level checker of the flocking steering block and its bind
`include "flocking_steering_rules_macros.svh"

module fsr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [5:0]  i_boid_index,
    input logic [31:0] i_delta_vx,
    input logic [31:0] i_delta_vy,
    input logic [1:0]  i_status,
    input logic        i_last
);
    // A stalled result holds its payload
    `FSR_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable({i_boid_index, i_delta_vx, i_delta_vy, i_status, i_last}), "result changed while stalled")

    // A small-flock result is a single zero result at boid zero
    `FSR_ASSERT_NOW(a_few_shape, i_out_valid && (i_status == fsr_pkg::ST_FEW), i_last && (i_boid_index == '0) && (i_delta_vx == '0) && (i_delta_vy == '0), "bad small-flock result")

    // Only defined status codes leave the block
    `FSR_ASSERT_NOW(a_status_code, i_out_valid, (i_status == fsr_pkg::ST_OK) || (i_status == fsr_pkg::ST_FEW) || (i_status == fsr_pkg::ST_OVF), "undefined status code")
endmodule

bind flocking_steering_rules fsr_checker u_fsr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_boid_index (o_out.boid_index),
    .i_delta_vx   (o_out.delta_vx),
    .i_delta_vy   (o_out.delta_vy),
    .i_status     (o_out.status),
    .i_last       (o_out.last)
);
